// ----- rtl/core/msp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-stepper pulse generator package
// Shared constants, codes and types for the step/direction pulse generator.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int MOTOR_IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int OUT_W       = 4;
    localparam int CHAR_W      = 8;
    localparam int CODE_W      = 4;
    localparam int COUNT_W     = 10;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 8'h39;

    typedef enum logic {
        OP_COMMAND = 1'b0,
        OP_TICK    = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFF_CODE       = 1'b0,
        CFG_CLOCKWISE_CODE = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic                   motor_ok;
        logic [MOTOR_IDX_W-1:0] motor;
        logic                   turn_off;
        logic                   count_ok;
        logic                   dir_level;
        logic [COUNT_W-1:0]     count;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/msp_cmd_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command decoder
// Turns the ASCII characters of a command word into a motor select, an
// on/off decision, a direction level and a binary step count.
// ----------------------------------------------------------------------------
module msp_cmd_decode (
    input  wire logic [msp_pkg::CHAR_W-1:0] motor_char,
    input  wire logic [msp_pkg::CHAR_W-1:0] enable_char,
    input  wire logic [msp_pkg::CHAR_W-1:0] direction_char,
    input  wire logic [msp_pkg::CHAR_W-1:0] hundreds_char,
    input  wire logic [msp_pkg::CHAR_W-1:0] tens_char,
    input  wire logic [msp_pkg::CHAR_W-1:0] ones_char,
    input  wire logic [msp_pkg::CODE_W-1:0] off_code,
    input  wire logic [msp_pkg::CODE_W-1:0] clockwise_code,
    output msp_pkg::cmd_t                   cmd
);

    logic [msp_pkg::CHAR_W-1:0]  motor_val;
    logic [msp_pkg::CHAR_W-1:0]  enable_val;
    logic [msp_pkg::CHAR_W-1:0]  direction_val;
    logic [msp_pkg::CHAR_W-1:0]  hundreds_val;
    logic [msp_pkg::CHAR_W-1:0]  tens_val;
    logic [msp_pkg::CHAR_W-1:0]  ones_val;
    logic                        hundreds_ok;
    logic                        tens_ok;
    logic                        ones_ok;
    logic [msp_pkg::COUNT_W-1:0] count_sum;

    assign motor_val     = motor_char - msp_pkg::ASCII_ZERO;
    assign enable_val    = enable_char - msp_pkg::ASCII_ZERO;
    assign direction_val = direction_char - msp_pkg::ASCII_ZERO;
    assign hundreds_val  = hundreds_char - msp_pkg::ASCII_ZERO;
    assign tens_val      = tens_char - msp_pkg::ASCII_ZERO;
    assign ones_val      = ones_char - msp_pkg::ASCII_ZERO;

    assign hundreds_ok = (hundreds_char >= msp_pkg::ASCII_ZERO)
                         && (hundreds_char <= msp_pkg::ASCII_NINE);
    assign tens_ok     = (tens_char >= msp_pkg::ASCII_ZERO)
                         && (tens_char <= msp_pkg::ASCII_NINE);
    assign ones_ok     = (ones_char >= msp_pkg::ASCII_ZERO)
                         && (ones_char <= msp_pkg::ASCII_NINE);

    // The digits are only used when all three are valid, so four bits each suffice.
    assign count_sum = msp_pkg::COUNT_W'(hundreds_val[3:0]) * msp_pkg::COUNT_W'(100)
                     + msp_pkg::COUNT_W'(tens_val[3:0]) * msp_pkg::COUNT_W'(10)
                     + msp_pkg::COUNT_W'(ones_val[3:0]);

    always_comb begin
        cmd.motor_ok  = (motor_char >= msp_pkg::ASCII_ZERO)
                        && (motor_val < msp_pkg::CHAR_W'(msp_pkg::MOTOR_COUNT));
        cmd.motor     = motor_val[msp_pkg::MOTOR_IDX_W-1:0];
        cmd.turn_off  = (enable_val == {{(msp_pkg::CHAR_W-msp_pkg::CODE_W){1'b0}}, off_code});
        cmd.count_ok  = hundreds_ok && tens_ok && ones_ok;
        cmd.dir_level = (direction_val
                         != {{(msp_pkg::CHAR_W-msp_pkg::CODE_W){1'b0}}, clockwise_code});
        cmd.count     = count_sum;
    end

endmodule

`default_nettype wire

// ----- rtl/core/multi_stepper_pulse_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-stepper pulse generator
// Step, direction and active-low enable lines for four stepper motors.
// ----------------------------------------------------------------------------
// Each input word is either a command, which sets one motor's enable,
// direction and three-digit step count from ASCII characters, or a tick,
// which toggles the step line of every motor with steps pending and counts
// a step on each falling edge. Every word produces exactly one result word
// holding the line levels after that word. A word is taken in every cycle in
// which the result side keeps up: the command decode and the per-motor updates
// are done in the cycle the word is accepted, and the result sits in an output
// register, so the result is presented in the cycle after the word is accepted
// and the throughput is one word per cycle whenever the result side keeps up.
// ----------------------------------------------------------------------------
module multi_stepper_pulse_generator (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_wr_en,
    input  wire logic [msp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [msp_pkg::CODE_W-1:0]        cfg_wdata,

    input  wire logic                              s_valid,
    output      logic                              s_ready,
    input  wire logic                              s_operation,
    input  wire logic [msp_pkg::CHAR_W-1:0]        s_motor_char,
    input  wire logic [msp_pkg::CHAR_W-1:0]        s_enable_char,
    input  wire logic [msp_pkg::CHAR_W-1:0]        s_direction_char,
    input  wire logic [msp_pkg::CHAR_W-1:0]        s_hundreds_char,
    input  wire logic [msp_pkg::CHAR_W-1:0]        s_tens_char,
    input  wire logic [msp_pkg::CHAR_W-1:0]        s_ones_char,

    output      logic                              m_valid,
    input  wire logic                              m_ready,
    output      logic [msp_pkg::OUT_W-1:0]         m_enable_lines,
    output      logic [msp_pkg::OUT_W-1:0]         m_direction_lines,
    output      logic [msp_pkg::OUT_W-1:0]         m_step_lines,
    output      logic [msp_pkg::OUT_W-1:0]         m_busy_motors,
    output      logic                              m_command_error
);

    localparam int MC = msp_pkg::MOTOR_COUNT;

    logic [msp_pkg::CODE_W-1:0]  off_code_reg;
    logic [msp_pkg::CODE_W-1:0]  clockwise_code_reg;

    logic [msp_pkg::COUNT_W-1:0] steps_left_reg [MC];
    logic [msp_pkg::COUNT_W-1:0] steps_left_next [MC];
    logic [MC-1:0]               step_level_reg;
    logic [MC-1:0]               step_level_next;
    logic [MC-1:0]               enable_level_reg;
    logic [MC-1:0]               enable_level_next;
    logic [MC-1:0]               direction_level_reg;
    logic [MC-1:0]               direction_level_next;
    logic [MC-1:0]               busy_now;
    logic [MC-1:0]               busy_next;
    logic                        error_next;

    logic                        m_valid_reg;
    logic [msp_pkg::OUT_W-1:0]   enable_out_reg;
    logic [msp_pkg::OUT_W-1:0]   direction_out_reg;
    logic [msp_pkg::OUT_W-1:0]   step_out_reg;
    logic [msp_pkg::OUT_W-1:0]   busy_out_reg;
    logic                        error_out_reg;
    logic [msp_pkg::OUT_W-1:0]   enable_out_next;
    logic [msp_pkg::OUT_W-1:0]   direction_out_next;
    logic [msp_pkg::OUT_W-1:0]   step_out_next;
    logic [msp_pkg::OUT_W-1:0]   busy_out_next;

    logic                        s_fire;
    msp_pkg::op_t                op;
    msp_pkg::cmd_t               cmd;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign op      = msp_pkg::op_t'(s_operation);

    msp_cmd_decode u_decode (
        .motor_char     (s_motor_char),
        .enable_char    (s_enable_char),
        .direction_char (s_direction_char),
        .hundreds_char  (s_hundreds_char),
        .tens_char      (s_tens_char),
        .ones_char      (s_ones_char),
        .off_code       (off_code_reg),
        .clockwise_code (clockwise_code_reg),
        .cmd            (cmd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_code_reg       <= '0;
            clockwise_code_reg <= '0;
        end else if (cfg_wr_en) begin
            case (msp_pkg::cfg_idx_t'(cfg_index))
                msp_pkg::CFG_OFF_CODE:       off_code_reg       <= cfg_wdata;
                msp_pkg::CFG_CLOCKWISE_CODE: clockwise_code_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        step_level_next      = step_level_reg;
        enable_level_next    = enable_level_reg;
        direction_level_next = direction_level_reg;
        error_next           = 1'b0;
        for (int i = 0; i < MC; i++) begin
            steps_left_next[i] = steps_left_reg[i];
            busy_now[i]        = (steps_left_reg[i] != '0);
        end
        case (op)
            msp_pkg::OP_TICK: begin
                for (int i = 0; i < MC; i++) begin
                    if (busy_now[i]) begin
                        step_level_next[i] = !step_level_reg[i];
                        if (step_level_reg[i]) begin
                            steps_left_next[i] = steps_left_reg[i] - 1'b1;
                        end
                    end
                end
            end
            msp_pkg::OP_COMMAND: begin
                error_next = !cmd.motor_ok || (!cmd.turn_off && !cmd.count_ok);
                for (int i = 0; i < MC; i++) begin
                    if (cmd.motor_ok && cmd.motor == msp_pkg::MOTOR_IDX_W'(i)) begin
                        if (cmd.turn_off) begin
                            enable_level_next[i] = 1'b1;
                            steps_left_next[i]   = '0;
                        end else if (cmd.count_ok) begin
                            enable_level_next[i]    = 1'b0;
                            direction_level_next[i] = cmd.dir_level;
                            steps_left_next[i]      = cmd.count;
                        end
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < MC; i++) begin
            busy_next[i] = (steps_left_next[i] != '0);
        end
        enable_out_next    = '0;
        direction_out_next = '0;
        step_out_next      = '0;
        busy_out_next      = '0;
        for (int i = 0; i < msp_pkg::OUT_W; i++) begin
            if (i < MC) begin
                enable_out_next[i]    = enable_level_next[i];
                direction_out_next[i] = direction_level_next[i];
                step_out_next[i]      = step_level_next[i];
                busy_out_next[i]      = busy_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_level_reg      <= '0;
            enable_level_reg    <= '1;
            direction_level_reg <= '0;
            for (int i = 0; i < MC; i++) begin
                steps_left_reg[i] <= '0;
            end
        end else if (s_fire) begin
            step_level_reg      <= step_level_next;
            enable_level_reg    <= enable_level_next;
            direction_level_reg <= direction_level_next;
            for (int i = 0; i < MC; i++) begin
                steps_left_reg[i] <= steps_left_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            enable_out_reg    <= enable_out_next;
            direction_out_reg <= direction_out_next;
            step_out_reg      <= step_out_next;
            busy_out_reg      <= busy_out_next;
            error_out_reg     <= error_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_enable_lines    = enable_out_reg;
    assign m_direction_lines = direction_out_reg;
    assign m_step_lines      = step_out_reg;
    assign m_busy_motors     = busy_out_reg;
    assign m_command_error   = error_out_reg;

    // A disabled motor never has steps pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_now & enable_level_reg) == '0)
        else $error("disabled motor has pending steps");

    // A tick never reports a command error.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && op == msp_pkg::OP_TICK |=> !error_out_reg)
        else $error("error flagged on a tick");

    // A tick leaves the step line of an idle motor alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && op == msp_pkg::OP_TICK
        |=> ((step_level_reg ^ $past(step_level_reg)) & ~$past(busy_now)) == '0)
        else $error("idle motor stepped");

    // A command changes the lines of at most one motor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && op == msp_pkg::OP_COMMAND
        |=> $onehot0((enable_level_reg ^ $past(enable_level_reg))
                     | (direction_level_reg ^ $past(direction_level_reg))))
        else $error("command touched more than one motor");

    // An accepted word always leaves a result waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid_reg)
        else $error("result lost after accept");

endmodule

`default_nettype wire

// ----- bench/multi_stepper_pulse_generator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-stepper pulse generator testbench
// Sends command and tick words over valid/ready with random idling on both
// sides and checks every result word against a cycle-free model of the four
// motor channels, across several settings of the off and clockwise codes.
// ----------------------------------------------------------------------------
module multi_stepper_pulse_generator_tb;

    localparam int DIRECTED_COUNT = 22;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_WORDS    = 65;
    localparam int HOLD_CYCLES    = 80;

    typedef struct packed {
        msp_pkg::op_t                op;
        logic [msp_pkg::CHAR_W-1:0] motor;
        logic [msp_pkg::CHAR_W-1:0] enable;
        logic [msp_pkg::CHAR_W-1:0] direction;
        logic [msp_pkg::CHAR_W-1:0] hundreds;
        logic [msp_pkg::CHAR_W-1:0] tens;
        logic [msp_pkg::CHAR_W-1:0] ones;
    } stim_word_t;

    typedef struct packed {
        logic [msp_pkg::OUT_W-1:0] enables;
        logic [msp_pkg::OUT_W-1:0] directions;
        logic [msp_pkg::OUT_W-1:0] steps;
        logic [msp_pkg::OUT_W-1:0] busy;
        logic                      error;
    } lines_t;

    typedef struct packed {
        stim_word_t word;
        logic       typed;
        lines_t     lines;
    } directed_row_t;

    localparam lines_t UNTYPED = '0;

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic [msp_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [msp_pkg::CODE_W-1:0]       cfg_wdata;
    logic                             s_valid;
    logic                             s_ready;
    logic                             s_operation;
    logic [msp_pkg::CHAR_W-1:0]       s_motor_char;
    logic [msp_pkg::CHAR_W-1:0]       s_enable_char;
    logic [msp_pkg::CHAR_W-1:0]       s_direction_char;
    logic [msp_pkg::CHAR_W-1:0]       s_hundreds_char;
    logic [msp_pkg::CHAR_W-1:0]       s_tens_char;
    logic [msp_pkg::CHAR_W-1:0]       s_ones_char;
    logic                             m_valid;
    logic                             m_ready;
    logic [msp_pkg::OUT_W-1:0]        m_enable_lines;
    logic [msp_pkg::OUT_W-1:0]        m_direction_lines;
    logic [msp_pkg::OUT_W-1:0]        m_step_lines;
    logic [msp_pkg::OUT_W-1:0]        m_busy_motors;
    logic                             m_command_error;

    logic [msp_pkg::COUNT_W-1:0] pending_steps [msp_pkg::MOTOR_COUNT];
    logic                        step_bit      [msp_pkg::MOTOR_COUNT];
    logic                        enable_bit    [msp_pkg::MOTOR_COUNT];
    logic                        dir_bit       [msp_pkg::MOTOR_COUNT];
    logic [msp_pkg::CODE_W-1:0]  disable_digit;
    logic [msp_pkg::CODE_W-1:0]  cw_digit;

    lines_t expected_lines [$];
    int     mismatches = 0;
    bit     calm = 1'b0;
    bit     hold_requested = 1'b0;

    directed_row_t directed_rows [DIRECTED_COUNT] = '{
        '{'{msp_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{4'hF, 4'h0, 4'h0, 4'h0, 1'b0}},
        '{'{msp_pkg::OP_COMMAND, "0", "1", "1", "9", "9", "9"}, 1'b1,
          '{4'hE, 4'h1, 4'h0, 4'h1, 1'b0}},
        '{'{msp_pkg::OP_COMMAND, "4", "1", "1", "0", "0", "1"}, 1'b1,
          '{4'hE, 4'h1, 4'h0, 4'h1, 1'b1}},
        '{'{msp_pkg::OP_COMMAND, 8'hFF, "1", "1", "0", "0", "1"}, 1'b1,
          '{4'hE, 4'h1, 4'h0, 4'h1, 1'b1}},
        '{'{msp_pkg::OP_COMMAND, 8'h00, "1", "1", "0", "0", "1"}, 1'b1,
          '{4'hE, 4'h1, 4'h0, 4'h1, 1'b1}},
        '{'{msp_pkg::OP_COMMAND, 8'h2F, "1", "1", "0", "0", "1"}, 1'b1,
          '{4'hE, 4'h1, 4'h0, 4'h1, 1'b1}},
        '{'{msp_pkg::OP_COMMAND, "3", "5", "0", "0", "0", 8'h2F}, 1'b1,
          '{4'hE, 4'h1, 4'h0, 4'h1, 1'b1}},
        '{'{msp_pkg::OP_COMMAND, "3", "5", "0", 8'h3A, "0", "0"}, 1'b1,
          '{4'hE, 4'h1, 4'h0, 4'h1, 1'b1}},
        '{'{msp_pkg::OP_COMMAND, "3", "5", "0", "0", 8'hFF, "0"}, 1'b1,
          '{4'hE, 4'h1, 4'h0, 4'h1, 1'b1}},
        '{'{msp_pkg::OP_COMMAND, "3", "1", "0", "0", "0", "0"}, 1'b1,
          '{4'h6, 4'h1, 4'h0, 4'h1, 1'b0}},
        '{'{msp_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, UNTYPED},
        '{'{msp_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, UNTYPED},
        '{'{msp_pkg::OP_COMMAND, "1", 8'h00, 8'hFF, "0", "0", "2"}, 1'b0, UNTYPED},
        '{'{msp_pkg::OP_TICK, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55}, 1'b0, UNTYPED},
        '{'{msp_pkg::OP_TICK, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}, 1'b0, UNTYPED},
        '{'{msp_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, UNTYPED},
        '{'{msp_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, UNTYPED},
        '{'{msp_pkg::OP_COMMAND, "0", "0", 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, UNTYPED},
        '{'{msp_pkg::OP_COMMAND, "2", "0", "1", 8'h00, 8'h00, 8'h00}, 1'b0, UNTYPED},
        '{'{msp_pkg::OP_COMMAND, "2", "9", "9", "0", "1", "0"}, 1'b0, UNTYPED},
        '{'{msp_pkg::OP_COMMAND, "3", "0", "0", "0", "0", "0"}, 1'b0, UNTYPED},
        '{'{msp_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, UNTYPED}
    };

    multi_stepper_pulse_generator u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_motor_char      (s_motor_char),
        .s_enable_char     (s_enable_char),
        .s_direction_char  (s_direction_char),
        .s_hundreds_char   (s_hundreds_char),
        .s_tens_char       (s_tens_char),
        .s_ones_char       (s_ones_char),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_enable_lines    (m_enable_lines),
        .m_direction_lines (m_direction_lines),
        .m_step_lines      (m_step_lines),
        .m_busy_motors     (m_busy_motors),
        .m_command_error   (m_command_error)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [msp_pkg::CHAR_W-1:0] char_value(
        input logic [msp_pkg::CHAR_W-1:0] c);
        return c - msp_pkg::ASCII_ZERO;
    endfunction

    function automatic logic is_ascii_digit(input logic [msp_pkg::CHAR_W-1:0] c);
        return c >= msp_pkg::ASCII_ZERO && c <= msp_pkg::ASCII_NINE;
    endfunction

    function automatic lines_t predict_lines(input stim_word_t w);
        lines_t r;
        int     m;
        r = '0;
        if (w.op == msp_pkg::OP_COMMAND) begin
            if (w.motor < msp_pkg::ASCII_ZERO
                || w.motor >= msp_pkg::ASCII_ZERO
                              + msp_pkg::CHAR_W'(msp_pkg::MOTOR_COUNT)) begin
                r.error = 1'b1;
            end else begin
                m = int'(w.motor - msp_pkg::ASCII_ZERO);
                if (char_value(w.enable) == {4'b0, disable_digit}) begin
                    enable_bit[m]    = 1'b1;
                    pending_steps[m] = '0;
                end else if (!is_ascii_digit(w.hundreds) || !is_ascii_digit(w.tens) ||
                             !is_ascii_digit(w.ones)) begin
                    r.error = 1'b1;
                end else begin
                    enable_bit[m]    = 1'b0;
                    dir_bit[m]       = char_value(w.direction) != {4'b0, cw_digit};
                    pending_steps[m] = msp_pkg::COUNT_W'(char_value(w.hundreds)) * 10'd100
                                     + msp_pkg::COUNT_W'(char_value(w.tens)) * 10'd10
                                     + msp_pkg::COUNT_W'(char_value(w.ones));
                end
            end
        end else begin
            for (int i = 0; i < msp_pkg::MOTOR_COUNT; i++) begin
                if (pending_steps[i] != '0) begin
                    step_bit[i] = ~step_bit[i];
                    if (!step_bit[i]) begin
                        pending_steps[i] = pending_steps[i] - 1'b1;
                    end
                end
            end
        end
        for (int i = 0; i < msp_pkg::MOTOR_COUNT && i < msp_pkg::OUT_W; i++) begin
            r.enables[i]    = enable_bit[i];
            r.directions[i] = dir_bit[i];
            r.steps[i]      = step_bit[i];
            r.busy[i]       = pending_steps[i] != '0;
        end
        return r;
    endfunction

    // Ticks and mostly well-formed commands aimed at the current codes, with small
    // counts so that motors run dry, and now and then one corrupted character.
    function automatic stim_word_t random_word();
        stim_word_t w;
        w.op        = ($urandom_range(0, 99) < 45) ? msp_pkg::OP_TICK : msp_pkg::OP_COMMAND;
        w.motor     = msp_pkg::ASCII_ZERO
                      + msp_pkg::CHAR_W'($urandom_range(0, msp_pkg::MOTOR_COUNT - 1));
        w.enable    = msp_pkg::ASCII_ZERO
                      + (($urandom_range(0, 2) == 0) ? msp_pkg::CHAR_W'(disable_digit)
                                                     : msp_pkg::CHAR_W'($urandom_range(0, 9)));
        w.direction = msp_pkg::ASCII_ZERO
                      + ($urandom_range(0, 1) ? msp_pkg::CHAR_W'(cw_digit)
                                              : msp_pkg::CHAR_W'($urandom_range(0, 9)));
        w.hundreds  = msp_pkg::ASCII_ZERO;
        w.tens      = msp_pkg::ASCII_ZERO + msp_pkg::CHAR_W'($urandom_range(0, 1));
        w.ones      = msp_pkg::ASCII_ZERO + msp_pkg::CHAR_W'($urandom_range(0, 9));
        if ($urandom_range(0, 15) == 0) begin
            w.hundreds = msp_pkg::ASCII_ZERO + msp_pkg::CHAR_W'($urandom_range(0, 9));
            w.tens     = msp_pkg::ASCII_ZERO + msp_pkg::CHAR_W'($urandom_range(0, 9));
        end
        case ($urandom_range(0, 19))
            0: w.motor = msp_pkg::CHAR_W'($urandom_range(0, 255));
            1: w.enable = msp_pkg::CHAR_W'($urandom_range(0, 255));
            2: w.direction = msp_pkg::CHAR_W'($urandom_range(0, 255));
            3: w.hundreds = msp_pkg::CHAR_W'($urandom_range(0, 255));
            4: w.tens = msp_pkg::CHAR_W'($urandom_range(0, 255));
            5: w.ones = msp_pkg::CHAR_W'($urandom_range(0, 255));
            default: ;
        endcase
        if (w.op == msp_pkg::OP_TICK) begin
            {w.motor, w.enable, w.direction, w.hundreds, w.tens, w.ones}
                = 48'({$urandom, $urandom});
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at %0t: got %0h, expected %0h", what, $time, got, want);
        mismatches++;
    endtask

    task automatic set_codes(input logic [msp_pkg::CODE_W-1:0] off,
                             input logic [msp_pkg::CODE_W-1:0] cw);
        cfg_wr_en <= 1'b1;
        cfg_index <= msp_pkg::CFG_OFF_CODE;
        cfg_wdata <= off;
        @(negedge aclk);
        cfg_index <= msp_pkg::CFG_CLOCKWISE_CODE;
        cfg_wdata <= cw;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        disable_digit = off;
        cw_digit      = cw;
        @(negedge aclk);
    endtask

    task automatic offer_word(input stim_word_t w, input logic typed, input lines_t typed_lines);
        lines_t predicted;
        int     gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_operation      <= w.op;
        s_motor_char     <= w.motor;
        s_enable_char    <= w.enable;
        s_direction_char <= w.direction;
        s_hundreds_char  <= w.hundreds;
        s_tens_char      <= w.tens;
        s_ones_char      <= w.ones;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_lines(w);
        expected_lines.push_back(typed ? typed_lines : predicted);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_lines.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin : result_ready_driver
        int stall;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_requested) begin
                stall = HOLD_CYCLES;
                hold_requested = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 13);
            end else begin
                stall = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : result_monitor
        lines_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_lines.size() == 0) begin
                report_mismatch("unexpected result word", 0, 0);
            end else begin
                want = expected_lines.pop_front();
                if (m_enable_lines !== want.enables)
                    report_mismatch("enable_lines", 32'(m_enable_lines), 32'(want.enables));
                if (m_direction_lines !== want.directions)
                    report_mismatch("direction_lines", 32'(m_direction_lines),
                                    32'(want.directions));
                if (m_step_lines !== want.steps)
                    report_mismatch("step_lines", 32'(m_step_lines), 32'(want.steps));
                if (m_busy_motors !== want.busy)
                    report_mismatch("busy_motors", 32'(m_busy_motors), 32'(want.busy));
                if (m_command_error !== want.error)
                    report_mismatch("command_error", 32'(m_command_error), 32'(want.error));
            end
        end
    end

    initial begin : stimulus
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = msp_pkg::CFG_OFF_CODE;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_operation      = msp_pkg::OP_COMMAND;
        s_motor_char     = '0;
        s_enable_char    = '0;
        s_direction_char = '0;
        s_hundreds_char  = '0;
        s_tens_char      = '0;
        s_ones_char      = '0;
        disable_digit    = '0;
        cw_digit         = '0;
        for (int i = 0; i < msp_pkg::MOTOR_COUNT; i++) begin
            pending_steps[i] = '0;
            step_bit[i]      = 1'b0;
            enable_bit[i]    = 1'b1;
            dir_bit[i]       = 1'b0;
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        set_codes(4'd0, 4'd0);

        for (int r = 0; r < DIRECTED_COUNT; r++) begin
            offer_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].lines);
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            s_valid <= 1'b0;
            wait_drained();
            case (p)
                0: set_codes(4'd9, 4'd9);
                1: set_codes(4'd0, 4'd9);
                2: set_codes(4'd9, 4'd0);
                5: set_codes(4'd3, 4'd7);
                default: set_codes(msp_pkg::CODE_W'($urandom_range(0, 9)),
                                   msp_pkg::CODE_W'($urandom_range(0, 9)));
            endcase
            // The first phase opens with a long result-side stall so that the
            // block backs up and holds off further input words.
            if (p == 0) hold_requested = 1'b1;
            if (p == PHASE_COUNT - 1) calm = 1'b1;
            repeat (PHASE_WORDS) offer_word(random_word(), 1'b0, UNTYPED);
        end
        s_valid <= 1'b0;

        while (expected_lines.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
